### design/rhht_pkg.sv
// Shared constants, codes and slot type for the Robin Hood hash table.
`default_nettype none
package rhht_pkg;
    localparam int MAX_SLOTS_DEF = 1024;
    localparam int HASH_W        = 32;
    localparam int VAL_W         = 8;
    localparam int DIST_W        = 4;
    localparam int SIZE_W        = 11;
    localparam int LIMIT_W       = 4;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 11'd1024;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd10;

    typedef enum logic [1:0] {
        ACT_FIND   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_NOT_FOUND = 3'd0,
        ST_FOUND     = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_PRESENT   = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5,
        ST_ZERO_KEY  = 3'd6
    } status_t;

    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_MAX_PROBE  = 1'b1;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [VAL_W-1:0]  value;
        logic [DIST_W-1:0] disp;
    } slot_t;
endpackage
`default_nettype wire

### design/rhht_if.sv
// Request and response channel interfaces.
`default_nettype none
interface rhht_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [rhht_pkg::HASH_W-1:0]  key_hash;
    logic [rhht_pkg::VAL_W-1:0]   value;
    modport source (output valid, action, key_hash, value, input ready);
    modport sink   (input valid, action, key_hash, value, output ready);
endinterface

interface rhht_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [rhht_pkg::HASH_W-1:0]  out_hash;
    logic [rhht_pkg::VAL_W-1:0]   out_value;
    modport source (output valid, status, out_hash, out_value, input ready);
    modport sink   (input valid, status, out_hash, out_value, output ready);
endinterface
`default_nettype wire

### design/robin_hood_hash_table.sv
// Robin Hood hash table: sequencer, divider and slot memory.
//
// Usage: one request on req (action, key_hash, value) yields one response on
// rsp (status, out_hash, out_value). Requests are taken one at a time; ready
// is high only while the block is idle. Configuration (table_size at index 0,
// the largest probe distance at index 1) is written through cfg_we /
// cfg_index / cfg_data.
// Sequence: the home slot comes from a restoring divider, one quotient bit a
// cycle. Each probed slot then takes a memory read, then a compare and write
// back; an insert that misses probes twice (lookup, then placement). A remove
// also reads and rewrites each entry that it shifts back. The slot memory has
// one read port and one write port, and its read is registered. Zero keys and
// unused actions skip the divider and go straight to the response.
// Reset: a clearing pass writes every one of MAX_SLOTS slots empty, one a
// cycle, before the first request is taken; configuration returns to 1024/10.
// Stall: the response is held in registers until rsp.ready; no new request is
// taken meanwhile.
`default_nettype none
module robin_hood_hash_table #(
    parameter int MAX_SLOTS = rhht_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    rhht_req_if.sink                           req,
    rhht_rsp_if.source                         rsp,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [rhht_pkg::SIZE_W-1:0]   cfg_data
);
    localparam int AW = $clog2(MAX_SLOTS);
    localparam int SW = AW + 1;
    localparam int CW = (SW > rhht_pkg::SIZE_W) ? SW : rhht_pkg::SIZE_W;
    localparam int HW = rhht_pkg::HASH_W;

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_DIV     = 10'b0000000100,
        S_LOC_RD  = 10'b0000001000,
        S_LOC_CHK = 10'b0000010000,
        S_INS_RD  = 10'b0000100000,
        S_INS_CHK = 10'b0001000000,
        S_REM_RD  = 10'b0010000000,
        S_REM_CHK = 10'b0100000000,
        S_OUT     = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [rhht_pkg::SIZE_W-1:0]  size_reg;
    logic [rhht_pkg::LIMIT_W-1:0] limit_reg;

    // Request context
    logic [1:0]                   act_reg, act_next;
    logic [HW-1:0]                key_reg, key_next;
    logic [rhht_pkg::VAL_W-1:0]   val_reg, val_next;
    logic [SW-1:0]                ts_reg, ts_next;
    logic [SW-1:0]                home_reg, home_next;

    // Divider
    logic [SW:0]                  rem_reg, rem_next;
    logic [4:0]                   bit_reg, bit_next;
    logic [SW:0]                  rem_shift;

    // Probe walk
    logic [SW-1:0]                idx_reg, idx_next;
    logic [4:0]                   dist_reg, dist_next;
    rhht_pkg::slot_t              carry_reg, carry_next;
    logic [AW:0]                  clr_reg, clr_next;

    // Response
    logic [2:0]                   st_reg, st_next;
    logic [HW-1:0]                oh_reg, oh_next;
    logic [rhht_pkg::VAL_W-1:0]   ov_reg, ov_next;

    // Memory ports
    rhht_pkg::slot_t              mem [MAX_SLOTS];
    rhht_pkg::slot_t              rdata_reg;
    rhht_pkg::slot_t              wdata;
    logic                         we;
    logic [AW-1:0]                waddr;
    logic [AW-1:0]                raddr;

    // Active size: zero reads as one, clamp at MAX_SLOTS
    logic [CW-1:0] size_ext;
    logic [CW-1:0] size_clamp;
    always_comb
    begin
        size_ext = CW'(size_reg);
        if (size_ext == '0)
            size_clamp = CW'(1);
        else if (size_ext > CW'(MAX_SLOTS))
            size_clamp = CW'(MAX_SLOTS);
        else
            size_clamp = size_ext;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= rhht_pkg::SIZE_RST;
            limit_reg <= rhht_pkg::LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rhht_pkg::CFG_TABLE_SIZE)
                size_reg <= cfg_data;
            else
                limit_reg <= cfg_data[rhht_pkg::LIMIT_W-1:0];
        end
    end

    assign rem_shift = {rem_reg[SW-1:0], key_reg[bit_reg]};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        ts_next    = ts_reg;
        home_next  = home_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        idx_next   = idx_reg;
        dist_next  = dist_reg;
        carry_next = carry_reg;
        clr_next   = clr_reg;
        st_next    = st_reg;
        oh_next    = oh_reg;
        ov_next    = ov_reg;
        we         = 1'b0;
        waddr      = idx_reg[AW-1:0];
        wdata      = carry_reg;
        raddr      = idx_reg[AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(MAX_SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next = req.action;
                    key_next = req.key_hash;
                    val_next = req.value;
                    ts_next  = SW'(size_clamp);
                    rem_next = '0;
                    bit_next = 5'd31;
                    oh_next  = '0;
                    ov_next  = '0;
                    if (req.action == rhht_pkg::ACT_NONE)
                    begin
                        st_next    = rhht_pkg::ST_NOT_FOUND;
                        state_next = S_OUT;
                    end
                    else if (req.key_hash == '0)
                    begin
                        st_next    = rhht_pkg::ST_ZERO_KEY;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // One restoring step per cycle
                if (rem_shift >= {1'b0, ts_reg})
                    rem_next = rem_shift - {1'b0, ts_reg};
                else
                    rem_next = rem_shift;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    home_next  = rem_next[SW-1:0];
                    idx_next   = rem_next[SW-1:0];
                    dist_next  = '0;
                    state_next = S_LOC_RD;
                end
            end
            S_LOC_RD, S_LOC_CHK:
            begin
                logic miss;
                miss = 1'b0;
                if (state_reg == S_LOC_RD)
                begin
                    if (dist_reg > 5'(limit_reg) || idx_reg >= ts_reg)
                        miss = 1'b1;
                    else
                        state_next = S_LOC_CHK;
                end
                else if (rdata_reg.hash == '0)
                    miss = 1'b1;
                else if (rdata_reg.hash == key_reg)
                begin
                    oh_next = rdata_reg.hash;
                    ov_next = rdata_reg.value;
                    if (act_reg == rhht_pkg::ACT_FIND)
                    begin
                        st_next    = rhht_pkg::ST_FOUND;
                        state_next = S_OUT;
                    end
                    else if (act_reg == rhht_pkg::ACT_INSERT)
                    begin
                        st_next    = rhht_pkg::ST_PRESENT;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        st_next    = rhht_pkg::ST_REMOVED;
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_REM_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    dist_next  = dist_reg + 1'b1;
                    state_next = S_LOC_RD;
                end
                if (miss)
                begin
                    if (act_reg == rhht_pkg::ACT_INSERT)
                    begin
                        idx_next   = home_reg;
                        dist_next  = '0;
                        carry_next = '{hash: key_reg, value: val_reg, disp: '0};
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        st_next    = rhht_pkg::ST_NOT_FOUND;
                        oh_next    = '0;
                        ov_next    = '0;
                        state_next = S_OUT;
                    end
                end
            end
            S_INS_RD:
            begin
                if (idx_reg >= ts_reg || dist_reg > 5'(limit_reg))
                begin
                    st_next    = rhht_pkg::ST_FULL;
                    oh_next    = carry_reg.hash;
                    ov_next    = carry_reg.value;
                    state_next = S_OUT;
                end
                else
                    state_next = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                wdata = '{hash: carry_reg.hash, value: carry_reg.value,
                          disp: dist_reg[rhht_pkg::DIST_W-1:0]};
                if (rdata_reg.hash == '0)
                begin
                    we         = 1'b1;
                    st_next    = rhht_pkg::ST_INSERTED;
                    oh_next    = key_reg;
                    ov_next    = val_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    // Swap with a richer resident and carry it on
                    if (5'(rdata_reg.disp) < dist_reg)
                    begin
                        we         = 1'b1;
                        carry_next = rdata_reg;
                        dist_next  = 5'(rdata_reg.disp) + 1'b1;
                    end
                    else
                        dist_next = dist_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_INS_RD;
                end
            end
            S_REM_RD:
            begin
                if (idx_reg >= ts_reg)
                begin
                    we         = 1'b1;
                    waddr      = AW'(idx_reg - 1'b1);
                    wdata      = '0;
                    state_next = S_OUT;
                end
                else
                    state_next = S_REM_CHK;
            end
            S_REM_CHK:
            begin
                we    = 1'b1;
                waddr = AW'(idx_reg - 1'b1);
                if (rdata_reg.hash != '0 && rdata_reg.disp != '0)
                begin
                    wdata = '{hash: rdata_reg.hash, value: rdata_reg.value,
                              disp: rdata_reg.disp - 1'b1};
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_REM_RD;
                end
                else
                begin
                    wdata      = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        ts_reg    <= ts_next;
        home_reg  <= home_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        idx_reg   <= idx_next;
        dist_reg  <= dist_next;
        carry_reg <= carry_next;
        st_reg    <= st_next;
        oh_reg    <= oh_next;
        ov_reg    <= ov_next;
    end

    // Slot memory
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = (state_reg == S_OUT);
    assign rsp.status    = st_reg;
    assign rsp.out_hash  = oh_reg;
    assign rsp.out_value = ov_reg;

    // Checks
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request taken while response pending");
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_OUT) |-> !we)
        else $error("memory written outside an operation");
    a_ins_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (we && state_reg == S_INS_CHK) |-> wdata.hash != '0)
        else $error("insert writes an empty entry");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |=> (rem_reg < {1'b0, ts_reg}))
        else $error("divider remainder out of range");
endmodule
`default_nettype wire

### bench/robin_hood_hash_table_test.sv
// Self-checking testbench for the Robin Hood hash table block.
`timescale 1ns / 1ps
module robin_hood_hash_table_test;
    import rhht_pkg::*;

    localparam int SLOTS      = MAX_SLOTS_DEF;
    localparam int CYCLE_CAP  = 1000000;

    typedef struct {
        action_t           act;
        logic [HASH_W-1:0] key;
        logic [VAL_W-1:0]  val;
    } request_t;

    typedef struct {
        status_t           st;
        logic [HASH_W-1:0] key;
        logic [VAL_W-1:0]  val;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [SIZE_W-1:0] cfg_data;

    rhht_req_if req ();
    rhht_rsp_if rsp ();

    robin_hood_hash_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the table and its registers
    logic [HASH_W-1:0] shadow_hash [SLOTS];
    logic [VAL_W-1:0]  shadow_val  [SLOTS];
    int                shadow_dist [SLOTS];
    int                shadow_count;
    int                shadow_size;
    int                shadow_limit;

    request_t  pending_requests [$];
    outcome_t  expected_outcomes [$];
    logic [HASH_W-1:0] key_pool [$];
    int  failures;
    int  cycles;
    bit  req_taken;
    bit  calm;
    int  send_gap;
    int  stall_gap;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic int active_slots();
        if (shadow_size == 0) return 1;
        if (shadow_size > SLOTS) return SLOTS;
        return shadow_size;
    endfunction

    function automatic int find_slot(logic [HASH_W-1:0] key);
        int ts;
        int idx;
        ts = active_slots();
        idx = int'(key % ts);
        for (int d = 0; d <= shadow_limit; d++) begin
            if (idx >= ts || shadow_hash[idx] == '0) return -1;
            if (shadow_hash[idx] == key) return idx;
            idx++;
        end
        return -1;
    endfunction

    // Apply one request to the shadow table and return its outcome
    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        int ts;
        int pos;
        int idx;
        int nx;
        int cd;
        int td;
        logic [HASH_W-1:0] ch;
        logic [HASH_W-1:0] th;
        logic [VAL_W-1:0] cv;
        logic [VAL_W-1:0] tv;
        o.st = ST_NOT_FOUND;
        o.key = '0;
        o.val = '0;
        ts = active_slots();
        if (r.act == ACT_NONE) return o;
        if (r.key == '0) begin
            o.st = ST_ZERO_KEY;
            return o;
        end
        pos = find_slot(r.key);
        if (r.act == ACT_FIND) begin
            if (pos >= 0) begin
                o.st = ST_FOUND;
                o.key = shadow_hash[pos];
                o.val = shadow_val[pos];
            end
            return o;
        end
        if (r.act == ACT_INSERT) begin
            if (pos >= 0) begin
                o.st = ST_PRESENT;
                o.key = shadow_hash[pos];
                o.val = shadow_val[pos];
                return o;
            end
            ch = r.key;
            cv = r.val;
            cd = 0;
            idx = int'(r.key % ts);
            forever begin
                if (idx >= ts || cd > shadow_limit) begin
                    o.st = ST_FULL;
                    o.key = ch;
                    o.val = cv;
                    return o;
                end
                if (shadow_hash[idx] == '0) begin
                    shadow_hash[idx] = ch;
                    shadow_val[idx] = cv;
                    shadow_dist[idx] = cd;
                    shadow_count++;
                    o.st = ST_INSERTED;
                    o.key = r.key;
                    o.val = r.val;
                    return o;
                end
                // resident nearer its home gives way to the carried entry
                if (shadow_dist[idx] < cd) begin
                    th = shadow_hash[idx];
                    tv = shadow_val[idx];
                    td = shadow_dist[idx];
                    shadow_hash[idx] = ch;
                    shadow_val[idx] = cv;
                    shadow_dist[idx] = cd;
                    ch = th;
                    cv = tv;
                    cd = td;
                end
                cd++;
                idx++;
            end
        end
        // remove with backward shift
        if (pos < 0) return o;
        o.st = ST_REMOVED;
        o.key = shadow_hash[pos];
        o.val = shadow_val[pos];
        if (shadow_count > 0) shadow_count--;
        nx = pos + 1;
        while (nx < ts && shadow_hash[nx] != '0 && shadow_dist[nx] > 0) begin
            shadow_hash[nx-1] = shadow_hash[nx];
            shadow_val[nx-1] = shadow_val[nx];
            shadow_dist[nx-1] = shadow_dist[nx] - 1;
            nx++;
        end
        shadow_hash[nx-1] = '0;
        shadow_val[nx-1] = '0;
        shadow_dist[nx-1] = 0;
        return o;
    endfunction

    // Request driver and response stalls, both on the falling edge
    always @(negedge clk) begin
        request_t r;
        if (rst_n) begin
            if (!(req.valid && !req_taken)) begin
                if (send_gap > 0 || pending_requests.size() == 0) begin
                    req.valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end else begin
                    r = pending_requests.pop_front();
                    req.valid <= 1'b1;
                    req.action <= r.act;
                    req.key_hash <= r.key;
                    req.value <= r.val;
                    send_gap = gap_length();
                end
            end
            if (stall_gap > 0) begin
                rsp.ready <= 1'b0;
                stall_gap--;
            end else begin
                rsp.ready <= 1'b1;
                stall_gap = gap_length();
            end
        end
    end

    // Monitor: register writes, accepted requests, response checks
    always @(posedge clk) begin
        request_t r;
        outcome_t e;
        req_taken <= rst_n && req.valid && req.ready;
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_index == CFG_TABLE_SIZE) shadow_size = int'(cfg_data);
                else shadow_limit = int'(cfg_data[LIMIT_W-1:0]);
            end
            if (req.valid && req.ready) begin
                r.act = action_t'(req.action);
                r.key = req.key_hash;
                r.val = req.value;
                expected_outcomes.push_back(apply_request(r));
            end
            if (rsp.valid && rsp.ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected response status=%0d hash=%h", rsp.status, rsp.out_hash);
                    failures++;
                end else begin
                    e = expected_outcomes.pop_front();
                    if (rsp.status !== e.st) begin
                        $error("status expected %0d actual %0d", e.st, rsp.status);
                        failures++;
                    end
                    if (rsp.out_hash !== e.key) begin
                        $error("out_hash expected %h actual %h", e.key, rsp.out_hash);
                        failures++;
                    end
                    if (rsp.out_value !== e.val) begin
                        $error("out_value expected %h actual %h", e.val, rsp.out_value);
                        failures++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("robin_hood_hash_table: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [SIZE_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_request(action_t act, logic [HASH_W-1:0] key, logic [VAL_W-1:0] val);
        request_t r;
        r.act = act;
        r.key = key;
        r.val = val;
        pending_requests.push_back(r);
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || expected_outcomes.size() != 0 || req.valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [HASH_W-1:0] pick_key();
        int r;
        logic [HASH_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 55 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
        // clustered keys crowd a few home slots even in a big table
        if (r < 80) k = ($urandom() & 32'hFFFF_FC00) | $urandom_range(0, 15);
        else k = $urandom();
        if (k == '0) k = 32'h1;
        if (key_pool.size() < 40) key_pool.push_back(k);
        else key_pool[$urandom_range(0, 39)] = k;
        return k;
    endfunction

    task automatic queue_random(int n);
        int r;
        action_t act;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) act = ACT_INSERT;
            else if (r < 70) act = ACT_FIND;
            else if (r < 95) act = ACT_REMOVE;
            else act = ACT_NONE;
            queue_request(act, pick_key(), VAL_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int sizes [9];
        int limits [9];
        sizes = '{1024, 4, 0, 2047, 16, 7, 64, 1, 1024};
        limits = '{10, 1, 0, 15, 3, 10, 6, 0, 10};
        for (int i = 0; i < SLOTS; i++) begin
            shadow_hash[i] = '0;
            shadow_val[i] = '0;
            shadow_dist[i] = 0;
        end
        shadow_count = 0;
        shadow_size = int'(SIZE_RST);
        shadow_limit = int'(LIMIT_RST);
        failures = 0;
        cycles = 0;
        calm = 1'b0;
        send_gap = 0;
        stall_gap = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TABLE_SIZE;
        cfg_data = '0;
        req.valid = 1'b0;
        req.action = ACT_FIND;
        req.key_hash = '0;
        req.value = '0;
        rsp.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset registers, corners of each operation
        queue_request(ACT_FIND, '0, 8'hFF);
        queue_request(ACT_NONE, 32'hFFFF_FFFF, 8'hFF);
        queue_request(ACT_INSERT, 32'hFFFF_FFFF, 8'hFF);
        queue_request(ACT_INSERT, 32'h1, 8'h00);
        queue_request(ACT_INSERT, 32'h1, 8'h5A);
        queue_request(ACT_INSERT, 32'h401, 8'h11);
        queue_request(ACT_INSERT, 32'h801, 8'h22);
        queue_request(ACT_INSERT, 32'h2, 8'h33);
        queue_request(ACT_FIND, 32'h801, 8'h00);
        queue_request(ACT_FIND, 32'h1234_5678, 8'h00);
        queue_request(ACT_REMOVE, 32'h1, 8'h00);
        queue_request(ACT_FIND, 32'h2, 8'h00);
        queue_request(ACT_REMOVE, 32'h1, 8'h00);
        queue_request(ACT_REMOVE, '0, 8'h00);
        queue_request(ACT_FIND, 32'hFFFF_FFFF, 8'h00);
        drain();
        write_reg(CFG_TABLE_SIZE, 11'd2);
        write_reg(CFG_MAX_PROBE, 11'd0);
        queue_request(ACT_INSERT, 32'h4, 8'hA1);
        queue_request(ACT_INSERT, 32'h6, 8'hA2);
        queue_request(ACT_INSERT, 32'h7, 8'hA3);
        queue_request(ACT_INSERT, 32'h9, 8'hA4);
        queue_request(ACT_REMOVE, 32'h4, 8'h00);
        queue_request(ACT_FIND, 32'h6, 8'h00);
        drain();

        // random phases over several register settings
        foreach (sizes[p]) begin
            write_reg(CFG_TABLE_SIZE, SIZE_W'(sizes[p]));
            write_reg(CFG_MAX_PROBE, SIZE_W'(limits[p]));
            calm = (p % 3 == 1);
            queue_random(70);
            drain();
        end

        repeat (100) @(posedge clk);
        if (failures == 0)
            $display("robin_hood_hash_table: match");
        else
            $display("robin_hood_hash_table: mismatch");
        $finish;
    end
endmodule
